@@ src/afs_pkg.sv @@
// Package for the animation frame selector: request and result types,
// opcode and register codes, widths and reset constants.
// No dependencies; every other file of the block imports it.
package afs_pkg;

  localparam int MAX_FRAMES_DEF = 16;

  localparam int OPC_W      = 1;
  localparam int ENTRY_W    = 4;
  localparam int DUR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int TOTAL_W    = 20;
  localparam int FRAME_W    = 4;
  localparam int FC_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // The remainder unit retires two dividend bits per cycle.
  localparam int DIV_STEPS = TIME_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DUR_W-1:0] DEFAULT_DUR = DUR_W'(100);

  localparam logic [OPC_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPC_W-1:0] OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MODE = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [ENTRY_W-1:0] entry_index;
    logic [DUR_W-1:0]   duration_value;
    logic [TIME_W-1:0]  elapsed_time;
  } afs_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               finished;
  } afs_resp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DIV,
    ST_PREP,
    ST_WALK
  } afs_state_t;

endpackage

@@ src/afs_rem.sv @@
// Remainder unit: elapsed time modulo the total duration, two bits per cycle
// by restoring division. Depends on afs_pkg for widths.
module afs_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [afs_pkg::TIME_W-1:0]    dividend,
  input  logic [afs_pkg::TOTAL_W-1:0]   divisor,
  output logic                          done,
  output logic [afs_pkg::TOTAL_W-1:0]   remainder
);
  import afs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    dvd_r, dvd_nxt;
  logic [TOTAL_W-1:0]   dsr_r, dsr_nxt;
  logic [TOTAL_W-1:0]   rem_r, rem_nxt;

  // One restoring step. The partial remainder stays below the divisor, so
  // a single compare and subtract keeps it there.
  function automatic logic [TOTAL_W-1:0] rem_step(input logic [TOTAL_W-1:0] r,
                                                  input logic b,
                                                  input logic [TOTAL_W-1:0] d);
    logic [TOTAL_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[TOTAL_W-1:0];
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = rem_step(rem_step(rem_r, dvd_r[TIME_W-1], dsr_r), dvd_r[TIME_W-2], dsr_r);
      dvd_nxt = {dvd_r[TIME_W-3:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ src/animation_frame_selector.sv @@
// Top level of the animation frame selector: duration table memory, total,
// configuration registers and the request sequencer.
// Depends on afs_pkg and instantiates afs_rem.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown on out_resp for one cycle with out_valid high,
// and the receiver cannot hold it off. After reset the block sweeps the
// duration table to 100 ticks per entry, one entry a cycle, so busy stays
// high until the sweep is done; no request is taken before that. A load
// makes one memory read of the old duration, then the write of the new one
// and the update of the running total. A query runs the remainder unit (two
// dividend bits a cycle), then walks table entries through the single memory
// read port, at most the frames in use; a query with looping off and the
// total reached answers on the next cycle, and a zero total skips the
// remainder unit. The configuration port is always ready; registers must be
// written only while the block is idle; the block itself does not enforce it.
module animation_frame_selector #(
  parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  afs_pkg::afs_req_t                 in_req,
  output logic                              out_valid,
  output afs_pkg::afs_resp_t                out_resp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [afs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import afs_pkg::*;

  // Table address width and width of a frame count (0..MAX_FRAMES).
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int NW    = (CNT_W > FC_W) ? CNT_W : FC_W;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(MAX_FRAMES * 100);

  afs_state_t state_r, state_nxt;

  // Configuration registers.
  logic [FC_W-1:0] frame_count_r;
  logic            loop_enable_r;
  logic            reverse_mode_r;

  // Running total and the request being worked on.
  logic [TOTAL_W-1:0] total_r, total_nxt;
  afs_req_t           req_r, req_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               fin_r, fin_nxt;
  logic [TOTAL_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  afs_resp_t out_resp_r, out_resp_nxt;

  // Duration table, one write port and one registered read port.
  logic [DUR_W-1:0] mem [MAX_FRAMES];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [DUR_W-1:0] mem_wd, rdata_r;

  logic               accept;
  logic [NW-1:0]      fc_ext, n_clamp;
  logic [CNT_W-1:0]   n_cfg;
  logic               q_done;
  logic               div_start, div_done;
  logic [TOTAL_W-1:0] div_rem;
  logic               ld_valid;
  logic [IDX_W+ENTRY_W-1:0] ld_addr_wide;
  logic [IDX_W-1:0]   ld_addr;
  logic               walk_hit, walk_last;
  logic [CNT_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   rd_pos, rd_phys;
  logic [CNT_W-1:0]   fin_cnt, frame_cnt;
  logic [CNT_W+FRAME_W-1:0] frame_wide;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Frames in use: zero acts as one, anything above the table depth as the depth.
  always_comb begin
    fc_ext = NW'(frame_count_r);
    if (fc_ext == '0) begin
      n_clamp = NW'(1);
    end else if (fc_ext > NW'(MAX_FRAMES)) begin
      n_clamp = NW'(MAX_FRAMES);
    end else begin
      n_clamp = fc_ext;
    end
    n_cfg = n_clamp[CNT_W-1:0];
  end

  assign q_done = (in_req.elapsed_time >= TIME_W'(total_r));

  // A load aimed past the table depth is dropped but still answers.
  assign ld_valid     = (32'(req_r.entry_index) < MAX_FRAMES);
  assign ld_addr_wide = (IDX_W + ENTRY_W)'(req_r.entry_index);
  assign ld_addr      = ld_addr_wide[IDX_W-1:0];

  // Walk: rdata_r holds the duration of position pos_r; the next position is
  // read in the same cycle, when the walk steps past pos_r.
  assign pos_inc   = pos_r + 1'b1;
  assign walk_hit  = ({{(TOTAL_W-DUR_W){1'b0}}, rdata_r} <= rem_r);
  assign walk_last = (pos_inc == n_r);

  assign div_start = accept && (in_req.opcode == OP_QUERY) &&
                     !(!loop_enable_r && q_done) && (total_r != '0);

  afs_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_req.elapsed_time),
    .divisor   (total_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(MAX_FRAMES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_req.opcode == OP_LOAD) begin
            state_nxt = ST_LOAD_RD;
          end else if (!loop_enable_r && q_done) begin
            state_nxt = ST_IDLE;
          end else if (total_r == '0) begin
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_LOAD_RD: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: state_nxt = ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_WALK;
      ST_WALK: begin
        if (!walk_hit || walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Frame from the count of entries stepped over: forward it is the count,
  // backward it counts down from the last frame; running off the end clamps.
  always_comb begin
    if (state_r == ST_WALK && walk_hit) begin
      fin_cnt = pos_inc;
    end else begin
      fin_cnt = pos_r;
    end
    if (fin_cnt == n_r) begin
      frame_cnt = reverse_mode_r ? '0 : n_r - 1'b1;
    end else begin
      frame_cnt = reverse_mode_r ? n_r - 1'b1 - fin_cnt : fin_cnt;
    end
  end

  // Read address of a walk position, mapped backward in reverse mode.
  always_comb begin
    rd_phys = reverse_mode_r ? n_r - 1'b1 - rd_pos : rd_pos;
  end

  // Datapath and memory control.
  always_comb begin
    total_nxt     = total_r;
    req_nxt       = req_r;
    n_nxt         = n_r;
    fin_nxt       = fin_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_resp_nxt  = out_resp_r;
    mem_we        = 1'b0;
    mem_wa        = ld_addr;
    mem_wd        = req_r.duration_value;
    mem_re        = 1'b0;
    mem_ra        = ld_addr;
    rd_pos        = '0;
    frame_wide    = (CNT_W + FRAME_W)'(frame_cnt);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = DEFAULT_DUR;
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          n_nxt   = n_cfg;
          fin_nxt = q_done;
          rem_nxt = '0;
          if (in_req.opcode == OP_QUERY && !loop_enable_r && q_done) begin
            frame_wide               = (CNT_W + FRAME_W)'(n_cfg - 1'b1);
            out_valid_nxt            = 1'b1;
            out_resp_nxt.frame_index = frame_wide[FRAME_W-1:0];
            out_resp_nxt.finished    = 1'b1;
          end
        end
      end
      ST_LOAD_RD: begin
        mem_re = ld_valid;
      end
      ST_LOAD_WR: begin
        if (ld_valid) begin
          mem_we    = 1'b1;
          total_nxt = total_r - {{(TOTAL_W-DUR_W){1'b0}}, rdata_r}
                    + {{(TOTAL_W-DUR_W){1'b0}}, req_r.duration_value};
        end
        out_valid_nxt            = 1'b1;
        out_resp_nxt.frame_index = '0;
        out_resp_nxt.finished    = 1'b0;
      end
      ST_DIV: begin
        if (div_done) begin
          rem_nxt = div_rem;
        end
      end
      ST_PREP: begin
        rd_pos  = '0;
        mem_re  = 1'b1;
        mem_ra  = rd_phys[IDX_W-1:0];
        pos_nxt = '0;
      end
      ST_WALK: begin
        if (walk_hit && !walk_last) begin
          rd_pos  = pos_inc;
          mem_re  = 1'b1;
          mem_ra  = rd_phys[IDX_W-1:0];
          rem_nxt = rem_r - {{(TOTAL_W-DUR_W){1'b0}}, rdata_r};
          pos_nxt = pos_inc;
        end else begin
          out_valid_nxt            = 1'b1;
          out_resp_nxt.frame_index = frame_wide[FRAME_W-1:0];
          out_resp_nxt.finished    = fin_r;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_r          <= '0;
      total_r        <= TOTAL_RESET;
      out_valid_r    <= 1'b0;
      frame_count_r  <= FC_W'(1);
      loop_enable_r  <= 1'b1;
      reverse_mode_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_COUNT:  frame_count_r  <= cfg_data[FC_W-1:0];
          CFG_LOOP_ENABLE:  loop_enable_r  <= cfg_data[0];
          CFG_REVERSE_MODE: reverse_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    n_r        <= n_nxt;
    fin_r      <= fin_nxt;
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    out_resp_r <= out_resp_nxt;
  end

  // Duration table.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

endmodule

@@ test/tb_animation_frame_selector.sv @@
// Self-checking testbench for animation_frame_selector: loads and queries with
// random gaps, register settings changed between phases, results checked in order.
// Depends on afs_pkg and the animation_frame_selector RTL only.
`timescale 1ns / 100ps

module tb_animation_frame_selector;
  import afs_pkg::*;

  // Index 3 is not a register; a write there must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int N_FRAMES = MAX_FRAMES_DEF;
  localparam int ITEMS_PER_PHASE = 137;
  localparam int N_PHASES = 12;
  // Each query also waits for the sender's gap, and there are about 1700
  // requests; the limit is set well above the slowest honest run.
  localparam int CYCLE_LIMIT = 400_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  afs_req_t in_req = '0;
  logic out_valid;
  afs_resp_t out_resp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  animation_frame_selector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_resp  (out_resp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Requests waiting to be driven, and the answers still owed by the block.
  afs_req_t req_pending[$];
  afs_resp_t frame_due[$];

  // The checker's own copy of the block state and its registers.
  logic [DUR_W-1:0]   frame_dur [N_FRAMES];
  logic [TOTAL_W-1:0] sum_dur;
  logic [FC_W-1:0]    cfg_frames;
  logic               cfg_loop;
  logic               cfg_reverse;

  // Mirror of the table kept on the generating side, so that query times
  // can be aimed at frame boundaries and at the loop length.
  int unsigned gen_dur [N_FRAMES];
  int gen_frames;
  int gen_made;

  int idle_pct;
  bit req_taken = 1'b0;
  int errors = 0;
  int cycle_cnt = 0;
  int n_load = 0;
  int n_query = 0;
  int n_done = 0;
  int n_zero = 0;
  int n_settings = 0;

  // Works out the answer to one request and applies a load to the state.
  function automatic afs_resp_t predict_frame(afs_req_t r);
    afs_resp_t res;
    int n;
    int frame;
    logic [TIME_W-1:0] rem;
    logic done;
    res = '0;
    if (r.opcode == OP_LOAD) begin
      sum_dur = TOTAL_W'(32'(sum_dur) - 32'(frame_dur[r.entry_index]) +
                         32'(r.duration_value));
      frame_dur[r.entry_index] = r.duration_value;
      return res;
    end
    n = (cfg_frames == 0) ? 1 : (cfg_frames > N_FRAMES) ? N_FRAMES : int'(cfg_frames);
    done = (r.elapsed_time >= TIME_W'(sum_dur));
    if (!cfg_loop && done) begin
      frame = n - 1;
    end else begin
      // The loop length is the whole table, even when fewer frames are used.
      rem = (sum_dur == 0) ? '0 : r.elapsed_time % TIME_W'(sum_dur);
      if (cfg_reverse) begin
        frame = n - 1;
        for (int i = n - 1; i >= 0; i--) begin
          if (rem >= TIME_W'(frame_dur[i])) begin
            rem -= TIME_W'(frame_dur[i]);
            frame--;
          end else begin
            break;
          end
        end
      end else begin
        frame = 0;
        for (int i = 0; i < n; i++) begin
          if (rem >= TIME_W'(frame_dur[i])) begin
            rem -= TIME_W'(frame_dur[i]);
            frame++;
          end else begin
            break;
          end
        end
      end
      // Walking past the frames in use, zero durations included, clamps.
      if (frame < 0) frame = 0;
      if (frame > n - 1) frame = n - 1;
    end
    res.frame_index = FRAME_W'(frame);
    res.finished = done;
    return res;
  endfunction

  // Driver: a request stays on the port until the block takes it. Inputs
  // change only on the falling edge, away from the edge that samples them.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_req <= req_pending.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest answer owed, follows the
  // register writes, and predicts every request the block takes.
  always @(posedge clk) begin
    afs_resp_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, frame_due.size());
      $display("CHECK FAILED");
      $finish;
    end else if (!rst_n) begin
      for (int i = 0; i < N_FRAMES; i++) frame_dur[i] = DEFAULT_DUR;
      sum_dur = TOTAL_W'(N_FRAMES * 100);
      cfg_frames = FC_W'(1);
      cfg_loop = 1'b1;
      cfg_reverse = 1'b0;
      req_taken <= 1'b0;
    end else begin
      if (out_valid === 1'b1) begin
        if (frame_due.size() == 0) begin
          errors++;
          $error("result with nothing outstanding: frame_index %0d finished %0d",
                 out_resp.frame_index, out_resp.finished);
        end else begin
          want = frame_due.pop_front();
          if (out_resp.frame_index !== want.frame_index) begin
            errors++;
            $error("frame_index: expected %0d, got %0d",
                   want.frame_index, out_resp.frame_index);
          end
          if (out_resp.finished !== want.finished) begin
            errors++;
            $error("finished: expected %0d, got %0d", want.finished, out_resp.finished);
          end
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_FRAME_COUNT:  cfg_frames = cfg_data[FC_W-1:0];
          CFG_LOOP_ENABLE:  cfg_loop = cfg_data[0];
          CFG_REVERSE_MODE: cfg_reverse = cfg_data[0];
          default: ;
        endcase
      end
      req_taken <= start && busy === 1'b0;
      if (start && busy === 1'b0) begin
        if (in_req.opcode == OP_LOAD) begin
          n_load++;
        end else begin
          n_query++;
          if (in_req.elapsed_time >= TIME_W'(sum_dur)) n_done++;
          if (sum_dur == 0) n_zero++;
        end
        frame_due = {frame_due, predict_frame(in_req)};
      end
    end
  end

  // Waits until every request has been taken and answered and the block
  // has dropped busy, so that registers can be written safely.
  task automatic wait_idle();
    do @(posedge clk);
    while (req_pending.size() != 0 || start || frame_due.size() != 0 || busy !== 1'b0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
  endtask

  // Writes all three registers. With junk set, the unused upper data bits
  // of the one-bit registers carry random values.
  task automatic configure(int fc, bit lp, bit rv, bit junk);
    logic [CFG_DATA_W-1:0] hi_lp;
    logic [CFG_DATA_W-1:0] hi_rv;
    hi_lp = junk ? CFG_DATA_W'($urandom_range(15) << 1) : '0;
    hi_rv = junk ? CFG_DATA_W'($urandom_range(15) << 1) : '0;
    cfg_write(CFG_FRAME_COUNT, CFG_DATA_W'(fc));
    cfg_write(CFG_LOOP_ENABLE, hi_lp | CFG_DATA_W'(lp));
    cfg_write(CFG_REVERSE_MODE, hi_rv | CFG_DATA_W'(rv));
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_frames = (fc == 0) ? 1 : (fc > N_FRAMES) ? N_FRAMES : fc;
    n_settings++;
  endtask

  // Fields a request does not use are always random.
  task automatic add_load(int idx, logic [DUR_W-1:0] dur);
    afs_req_t r;
    r.opcode = OP_LOAD;
    r.entry_index = ENTRY_W'(idx);
    r.duration_value = dur;
    r.elapsed_time = $urandom();
    gen_dur[idx] = dur;
    req_pending = {req_pending, r};
    gen_made++;
  endtask

  task automatic add_query(logic [TIME_W-1:0] elapsed);
    afs_req_t r;
    r.opcode = OP_QUERY;
    r.entry_index = ENTRY_W'($urandom_range(15));
    r.duration_value = DUR_W'($urandom_range(65535));
    r.elapsed_time = elapsed;
    req_pending = {req_pending, r};
    gen_made++;
  endtask

  function automatic int unsigned gen_span(int lo, int hi);
    int unsigned s;
    s = 0;
    for (int i = lo; i < hi; i++) s += gen_dur[i];
    return s;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(9))
      0, 1:    return '0;
      2, 3, 4: return DUR_W'($urandom_range(1, 300));
      5:       return DUR_W'(16'hFFFF - $urandom_range(1));
      default: return DUR_W'($urandom_range(65535));
    endcase
  endfunction

  // Query times cluster where the answer changes: around the loop length,
  // and around frame edges in both walking directions a few loops in.
  function automatic logic [TIME_W-1:0] pick_elapsed();
    int unsigned s;
    int unsigned p;
    int j;
    s = gen_span(0, N_FRAMES);
    j = $urandom_range(gen_frames);
    p = $urandom_range(1) ? gen_span(0, j) : gen_span(j, gen_frames);
    case ($urandom_range(9))
      0, 1:    return TIME_W'($urandom_range(2 * s + 2));
      2, 3:    return TIME_W'(s + $urandom_range(2) - 1);
      4, 5:    return TIME_W'($urandom_range(3) * s + p + $urandom_range(2) - 1);
      6:       return $urandom();
      7:       return $urandom_range(1) ? '0 : '1;
      default: return TIME_W'($urandom_range(300));
    endcase
  endfunction

  // Random part of one phase: mostly bursts of queries between table
  // updates, with whole-table rewrites (all zero among them) and noise.
  task automatic run_random(int count);
    int base;
    int len;
    int style;
    int big;
    gen_made = 0;
    while (gen_made < count) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          len = $urandom_range(1, 8);
          repeat (len) add_query(pick_elapsed());
        end
        12, 13, 14, 15: begin
          len = $urandom_range(1, 4);
          repeat (len) add_load($urandom_range(15), pick_duration());
        end
        16, 17: begin
          base = $urandom_range(15);
          style = $urandom_range(2);
          big = $urandom_range(15);
          for (int i = 0; i < N_FRAMES; i++) begin
            case (style)
              0: add_load((base + i) % N_FRAMES, '0);
              1: add_load((base + i) % N_FRAMES, DUR_W'($urandom_range(1, 30)));
              default: add_load((base + i) % N_FRAMES,
                                ((base + i) % N_FRAMES == big) ? pick_duration() : '0);
            endcase
          end
        end
        default: begin
          if ($urandom_range(1)) add_query($urandom());
          else add_load($urandom_range(15), DUR_W'($urandom_range(65535)));
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < N_FRAMES; i++) gen_dur[i] = 100;
    gen_frames = 1;
    idle_pct = 30;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    // The block clears its table after reset; wait for it to go idle.
    wait_idle();

    // Reset settings: one frame in use while the loop spans all sixteen.
    add_query('0);
    add_query(TIME_W'(1599));
    add_query(TIME_W'(1600));
    add_query('1);
    add_load(0, '0);
    add_load(15, 16'hFFFF);
    add_load(5, '0);
    wait_idle();
    // Table now sums to 66835 ticks. Hold the last frame, walk backward.
    configure(16, 1'b0, 1'b1, 1'b0);
    add_query(TIME_W'(66834));
    add_query(TIME_W'(66835));
    add_query('0);
    add_query(TIME_W'(65535));
    wait_idle();
    // A frame count of zero behaves as one; a zero first entry overruns.
    configure(0, 1'b1, 1'b0, 1'b0);
    add_query(TIME_W'(5));
    add_query(TIME_W'(2 * 66835 + 3));
    wait_idle();
    // A count above the table size is clamped; looping in reverse.
    configure(31, 1'b1, 1'b1, 1'b0);
    add_query(TIME_W'(200));
    add_query(TIME_W'(66834));
    wait_idle();
    cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(31)));
    configure(16, 1'b1, 1'b0, 1'b0);
    add_query(TIME_W'(66834));
    add_query(TIME_W'(100));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      idle_pct = (ph < 4) ? 30 : (ph < 8) ? 55 : 0;
      case (ph)
        0: configure(1, 1'b1, 1'b0, 1'b0);
        1: configure(16, 1'b1, 1'b0, 1'b0);
        2: configure(16, 1'b1, 1'b1, 1'b0);
        3: configure(16, 1'b0, 1'b0, 1'b0);
        4: configure(16, 1'b0, 1'b1, 1'b0);
        5: configure(0, 1'b1, 1'b1, 1'b0);
        6: configure(31, 1'b0, 1'b0, 1'b0);
        7: configure(8, 1'b1, 1'b0, 1'b0);
        8: configure(5, 1'b1, 1'b1, 1'b0);
        9: configure(17, 1'b1, 1'b1, 1'b0);
        default: configure($urandom_range(31), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'b1);
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    wait_idle();
    // A late or spurious result would still show up within a query's latency.
    repeat (40) @(posedge clk);
    if (frame_due.size() != 0) begin
      errors++;
      $error("%0d results never arrived", frame_due.size());
    end
    $display("Ran %0d loads and %0d queries under %0d register settings,",
             n_load, n_query, n_settings);
    $display("%0d queries past the loop length and %0d with a zero total; %0d errors.",
             n_done, n_zero, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
